// File: rtl/hms_pkg.sv
// Shared types and constants for the HH[:]MM[[:]SS] time string parser.
package hms_pkg;

    // Character classes.
    localparam logic [7:0] CharZero  = 8'h30;
    localparam logic [7:0] CharNine  = 8'h39;
    localparam logic [7:0] CharColon = 8'h3A;
    localparam logic [7:0] CharNul   = 8'h00;

    // Range limits, sized to the two-digit value width.
    localparam logic [6:0] HourMax     = 7'd23;
    localparam logic [6:0] HourMaxLeap = 7'd24;
    localparam logic [6:0] MinMax      = 7'd59;
    localparam logic [6:0] SecMax      = 7'd59;
    localparam logic [6:0] SecMaxLeap  = 7'd60;

    // Character queue between the front and the back.
    localparam int QDepth = 4;
    localparam int QAw    = $clog2(QDepth);
    localparam int QCw    = $clog2(QDepth + 1);

    // Mode register fields, bit 4 down to bit 0.
    typedef struct packed {
        logic req_term;
        logic leap_sec;
        logic no_sec;
        logic no_sep;
        logic leap_hour;
    } t_mode;

    // One classified character as it travels through the queue.
    typedef struct packed {
        logic       is_dig;
        logic       is_col;
        logic       is_nul;
        logic [3:0] dval;
    } t_char;

    // One result beat.
    typedef struct packed {
        logic       ok;
        logic [4:0] hours;
        logic [5:0] minutes;
        logic [5:0] seconds;
        logic [3:0] used;
    } t_result;

endpackage

// File: rtl/hms_time_parser.sv
// Top level of the streaming HH[:]MM[[:]SS] time string parser.
// The character that decides a result is first written into the character queue; once the
// parser pops it, the result beat is registered in the result stage and then offered.
// Throughput: one character per cycle; each character needs one step of the parser state
// machine, and a four-beat character queue lets input and output stall independently.
// A result held by a stalled consumer stops the parser until it is taken.
// Reset (synchronous, active low) clears the queue, the parser state and the mode register.
// After reset the parser waits for the first hour digit of a new string.
module hms_time_parser (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_ch,
    output logic       o_valid,
    input  logic       i_ready,
    output logic       o_ok,
    output logic [4:0] o_hours,
    output logic [5:0] o_minutes,
    output logic [5:0] o_seconds,
    output logic [3:0] o_used_chars,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [4:0] i_mode_bits
);

    logic             r_mode;
    hms_pkg::t_mode   r_mode_bits;
    logic             item_valid;
    hms_pkg::t_char   item;
    logic             pop;
    hms_pkg::t_result res;

    // Mode register; a configuration beat is always taken.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode_bits <= '0;
            r_mode      <= 1'b0;
        end else if (i_cfg_valid) begin
            r_mode_bits <= hms_pkg::t_mode'(i_mode_bits);
            r_mode      <= 1'b1;
        end
    end

    hms_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_ch         (i_ch),
        .o_item_valid (item_valid),
        .o_item       (item),
        .i_pop        (pop)
    );

    hms_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_mode       (r_mode_bits),
        .i_item_valid (item_valid),
        .i_item       (item),
        .o_pop        (pop),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_result     (res)
    );

    assign o_ok         = res.ok;
    assign o_hours      = res.hours;
    assign o_minutes    = res.minutes;
    assign o_seconds    = res.seconds;
    assign o_used_chars = res.used;

    // The mode register changes only on a configuration beat.
    a_mode_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode && !i_cfg_valid) |=> $stable(r_mode_bits))
        else $error("mode register changed without a configuration beat");

    // Every result beat follows a popped character.
    a_res_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(pop))
        else $error("result beat without a character");

    // Nothing is popped while the queue is empty.
    a_pop_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> item_valid)
        else $error("parser took a character that was not queued");

endmodule

// File: rtl/hms_front.sv
// Front end: accepts characters, classifies them and queues them for the parser.
module hms_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  logic [7:0]     i_ch,
    output logic           o_item_valid,
    output hms_pkg::t_char o_item,
    input  logic           i_pop
);

    hms_pkg::t_char                 r_mem [hms_pkg::QDepth];
    logic [hms_pkg::QAw-1:0]        r_wptr;
    logic [hms_pkg::QAw-1:0]        r_rptr;
    logic [hms_pkg::QCw-1:0]        r_cnt;
    hms_pkg::t_char                 cls;
    logic                           push;

    // Classify the incoming character.
    always_comb begin
        cls.is_dig = (i_ch >= hms_pkg::CharZero) && (i_ch <= hms_pkg::CharNine);
        cls.is_col = (i_ch == hms_pkg::CharColon);
        cls.is_nul = (i_ch == hms_pkg::CharNul);
        cls.dval   = 4'(i_ch - hms_pkg::CharZero);
    end

    assign o_ready      = (r_cnt != hms_pkg::QCw'(hms_pkg::QDepth));
    assign push         = i_valid && o_ready;
    assign o_item_valid = (r_cnt != '0);
    assign o_item       = r_mem[r_rptr];

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wptr] <= cls;
        end
    end

    // Queue pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // The back never pops an empty queue.
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_cnt != '0))
        else $error("pop from empty character queue");

    // The fill count never exceeds the depth.
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= hms_pkg::QCw'(hms_pkg::QDepth))
        else $error("character queue count out of range");

    // A character classified as digit is neither colon nor zero byte.
    a_cls_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_item_valid |-> !(o_item.is_dig && (o_item.is_col || o_item.is_nul)))
        else $error("queued character has conflicting classes");

endmodule

// File: rtl/hms_back.sv
// Back end: the time parsing state machine and the registered result stage.
module hms_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  hms_pkg::t_mode   i_mode,
    input  logic             i_item_valid,
    input  hms_pkg::t_char   i_item,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_ready,
    output hms_pkg::t_result o_result
);

    typedef enum logic [3:0] {
        PH_H1, PH_H2, PH_SEP, PH_M1, PH_M2, PH_AFTM, PH_S1, PH_S2, PH_TERM, PH_SKIP
    } t_phase;

    t_phase           r_phase, n_phase;
    logic [3:0]       r_tens, n_tens;
    logic [4:0]       r_hour, n_hour;
    logic [5:0]       r_min, n_min;
    logic [5:0]       r_sec, n_sec;
    logic             r_colon, n_colon;
    logic [3:0]       r_cnt, n_cnt;
    logic             r_ov, n_ov;
    hms_pkg::t_result r_res, n_res;

    logic             emit;
    logic             good;
    logic             do_m1;
    logic             do_s1;
    logic [6:0]       val;
    logic [6:0]       hour_lim;
    logic [6:0]       sec_lim;

    // Two-digit value from the held tens digit and the current digit.
    assign val      = {r_tens, 3'b000} + {2'b00, r_tens, 1'b0} + {3'b000, i_item.dval};
    assign hour_lim = i_mode.leap_hour ? hms_pkg::HourMaxLeap : hms_pkg::HourMax;
    assign sec_lim  = i_mode.leap_sec ? hms_pkg::SecMaxLeap : hms_pkg::SecMax;

    // A character is taken whenever the result stage can hold a new beat.
    assign o_pop = i_item_valid && (!r_ov || i_ready);

    // One parser step per popped character.
    always_comb begin
        n_phase = r_phase;
        n_tens  = r_tens;
        n_hour  = r_hour;
        n_min   = r_min;
        n_sec   = r_sec;
        n_colon = r_colon;
        n_cnt   = r_cnt;
        emit    = 1'b0;
        good    = 1'b0;
        do_m1   = 1'b0;
        do_s1   = 1'b0;
        case (r_phase)
            PH_H1: begin
                if (!i_item.is_dig) begin
                    emit = 1'b1;
                end else begin
                    n_tens  = i_item.dval;
                    n_cnt   = r_cnt + 1'b1;
                    n_phase = PH_H2;
                end
            end
            PH_H2: begin
                if (!i_item.is_dig || (val > hour_lim)) begin
                    emit = 1'b1;
                end else begin
                    n_hour  = val[4:0];
                    n_cnt   = r_cnt + 1'b1;
                    n_phase = PH_SEP;
                end
            end
            PH_SEP: begin
                if (i_item.is_col) begin
                    n_colon = 1'b1;
                    n_cnt   = r_cnt + 1'b1;
                    n_phase = PH_M1;
                end else if (!i_mode.no_sep) begin
                    emit = 1'b1;
                end else begin
                    n_colon = 1'b0;
                    do_m1   = 1'b1;
                end
            end
            PH_M1: begin
                do_m1 = 1'b1;
            end
            PH_M2: begin
                if (!i_item.is_dig || (val > hms_pkg::MinMax)) begin
                    emit = 1'b1;
                end else begin
                    n_min   = val[5:0];
                    n_cnt   = r_cnt + 1'b1;
                    n_phase = PH_AFTM;
                end
            end
            PH_AFTM: begin
                if (r_colon) begin
                    if (i_item.is_col) begin
                        n_cnt   = r_cnt + 1'b1;
                        n_phase = PH_S1;
                    end else if (i_mode.no_sec) begin
                        n_sec = '0;
                        emit  = 1'b1;
                        good  = !(i_mode.req_term && !i_item.is_nul);
                    end else begin
                        emit = 1'b1;
                    end
                end else if (i_mode.no_sec && !i_item.is_dig) begin
                    n_sec = '0;
                    emit  = 1'b1;
                    good  = !(i_mode.req_term && !i_item.is_nul);
                end else begin
                    do_s1 = 1'b1;
                end
            end
            PH_S1: begin
                do_s1 = 1'b1;
            end
            PH_S2: begin
                if (!i_item.is_dig || (val > sec_lim)) begin
                    emit = 1'b1;
                end else begin
                    n_sec = val[5:0];
                    n_cnt = r_cnt + 1'b1;
                    if (i_mode.req_term) begin
                        n_phase = PH_TERM;
                    end else begin
                        emit = 1'b1;
                        good = 1'b1;
                    end
                end
            end
            PH_TERM: begin
                // The terminator check follows the mode at this step.
                emit = 1'b1;
                good = !(i_mode.req_term && !i_item.is_nul);
            end
            PH_SKIP: begin
                if (i_item.is_nul) begin
                    n_phase = PH_H1;
                end
            end
            default: begin
                n_phase = PH_H1;
            end
        endcase

        // Minute tens digit, also reached straight from the hours when the separator is absent.
        if (do_m1) begin
            if (!i_item.is_dig) begin
                emit = 1'b1;
            end else begin
                n_tens  = i_item.dval;
                n_cnt   = r_cnt + 1'b1;
                n_phase = PH_M2;
            end
        end

        // Seconds tens digit, also reached straight from the minutes.
        if (do_s1) begin
            if (!i_item.is_dig) begin
                emit = 1'b1;
            end else begin
                n_tens  = i_item.dval;
                n_cnt   = r_cnt + 1'b1;
                n_phase = PH_S2;
            end
        end

        // Build the result from the updated values, then clear the string state when a result is emitted.
        n_res.ok      = good;
        n_res.hours   = good ? n_hour : '0;
        n_res.minutes = good ? n_min : '0;
        n_res.seconds = good ? n_sec : '0;
        n_res.used    = good ? n_cnt : '0;
        if (emit) begin
            n_tens  = '0;
            n_hour  = '0;
            n_min   = '0;
            n_sec   = '0;
            n_colon = 1'b0;
            n_cnt   = '0;
            n_phase = i_item.is_nul ? PH_H1 : PH_SKIP;
        end
    end

    // Result stage: holds a beat until the consumer takes it.
    always_comb begin
        n_ov = r_ov;
        if (o_pop && emit) begin
            n_ov = 1'b1;
        end else if (r_ov && i_ready) begin
            n_ov = 1'b0;
        end
    end

    // Parser state and result valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_H1;
            r_tens  <= '0;
            r_hour  <= '0;
            r_min   <= '0;
            r_sec   <= '0;
            r_colon <= 1'b0;
            r_cnt   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_ov <= n_ov;
            if (o_pop) begin
                r_phase <= n_phase;
                r_tens  <= n_tens;
                r_hour  <= n_hour;
                r_min   <= n_min;
                r_sec   <= n_sec;
                r_colon <= n_colon;
                r_cnt   <= n_cnt;
            end
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (o_pop && emit) begin
            r_res <= n_res;
        end
    end

    assign o_valid  = r_ov;
    assign o_result = r_res;

    // A successful parse consumed between four and eight characters.
    a_ok_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_res.ok) |-> ((r_res.used >= 4'd4) && (r_res.used <= 4'd8)))
        else $error("successful result with impossible character count");

    // A failed parse reports all fields as zero.
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !r_res.ok) |->
            ((r_res.hours == '0) && (r_res.minutes == '0) &&
             (r_res.seconds == '0) && (r_res.used == '0)))
        else $error("failed result carries nonzero fields");

    // While skipping the rest of a string, no per-string value survives.
    a_skip_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_SKIP) |-> ((r_cnt == '0) && (r_hour == '0) && !r_colon))
        else $error("string state not cleared after a result");

    // A held result is not overwritten while the consumer stalls.
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !i_ready) |-> !o_pop)
        else $error("character popped while result stage is blocked");

endmodule
